// ===== rtl/core/sira_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliced ID range allocator package
// Shared widths, register indexes, reset values and the controller states.
// ----------------------------------------------------------------------------
package sira_pkg;

    localparam int TXN_W    = 32;
    localparam int SIDX_W   = 16;
    localparam int ID_W     = 64;
    localparam int WAYO_W   = 4;
    localparam int CNT_W    = 16;
    localparam int SB_MAX   = 16;
    localparam int MOD_BITS = 4;
    localparam int SCAN_W   = 8;
    localparam int APB_AW   = 6;
    localparam int APB_DW   = 64;

    localparam logic [2:0] REG_SLICE_BITS  = 3'd0;
    localparam logic [2:0] REG_SLICES      = 3'd1;
    localparam logic [2:0] REG_WAYS        = 3'd2;
    localparam logic [2:0] REG_DEPTH       = 3'd3;
    localparam logic [2:0] REG_CHUNK       = 3'd4;
    localparam logic [2:0] REG_FIRST_START = 3'd5;

    localparam logic [4:0]  RST_SLICE_BITS  = 5'd8;
    localparam logic [6:0]  RST_SLICES      = 7'd64;
    localparam logic [4:0]  RST_WAYS        = 5'd1;
    localparam logic [3:0]  RST_DEPTH       = 4'd8;
    localparam logic [63:0] RST_CHUNK       = 64'd16384;
    localparam logic [63:0] RST_FIRST_START = 64'd0;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_IDX = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHK,
        ST_SLOT,
        ST_META,
        ST_SCAN,
        ST_NEXT,
        ST_CRD,
        ST_UPD,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/sira_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliced ID range allocator channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface sira_req_if;
    logic                        valid;
    logic                        ready;
    logic [sira_pkg::TXN_W-1:0]  txn_number;
    logic                        slice_named;
    logic [sira_pkg::SIDX_W-1:0] slice_index;

    modport source (output valid, txn_number, slice_named, slice_index, input ready);
    modport sink (input valid, txn_number, slice_named, slice_index, output ready);
endinterface

interface sira_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [sira_pkg::ID_W-1:0]   new_id;
    logic [sira_pkg::WAYO_W-1:0] way_used;
    logic                        status;

    modport source (output valid, new_id, way_used, status, input ready);
    modport sink (input valid, new_id, way_used, status, output ready);
endinterface

// ===== rtl/core/sliced_id_range_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliced ID range allocator
// Hands out unique 64-bit IDs from per-way histories of sliced ranges.
// ----------------------------------------------------------------------------
// Usage:
// A request transfer on i_req carries a transaction number and an optional
// slice index. One response transfer on o_rsp follows for every request,
// with the ID, the way it was drawn from and a status bit.
// One request is handled at a time. The way is found by a remainder unit that
// takes 4 bits of the transaction number per cycle, and the slice check
// follows it. A history slot that cannot serve goes through the metadata
// read, the check and the step to the next slot, and the free scan looks at
// 8 slices at a time. Serving from a slot takes the metadata read, the free
// scan for an unnamed slice, the slice counter read and write-back and a step
// for the result; a claim into an empty slot skips the metadata read and the
// scan, and a rejected slice goes from the check straight to the result.
// A request is taken only in the idle state; a finished response waits in
// the output register while the receiver stalls, and the next request can be
// taken in the cycle after that response is loaded.
// Reset clears the valid bits of all slots and sets the slot order of every
// way back to identity; memory contents need no clearing. Configuration is
// to be written through the APB port while no request is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module sliced_id_range_allocator #(
    parameter int MAX_WAYS    = 16,
    parameter int MAX_HISTORY = 8,
    parameter int MAX_SLICES  = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sira_req_if.sink                      i_req,
    sira_rsp_if.source                    o_rsp,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [sira_pkg::APB_AW-1:0]   i_paddr,
    input  logic [sira_pkg::APB_DW-1:0]   i_pwdata,
    output logic [sira_pkg::APB_DW-1:0]   o_prdata,
    output logic                          o_pready
);

    localparam int WW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WR      = $clog2(MAX_WAYS + 1);
    localparam int HW      = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int DW      = $clog2(MAX_HISTORY + 1);
    localparam int SW      = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int NW      = $clog2(MAX_SLICES + 1);
    localparam int PW      = $clog2(MAX_SLICES + sira_pkg::SCAN_W + 1);
    localparam int SLOTS   = MAX_WAYS * MAX_HISTORY;
    localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CDEPTH  = SLOTS * MAX_SLICES;
    localparam int CAW     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int OFW     = SW + sira_pkg::SB_MAX + 1;
    localparam int MOD_CYC = sira_pkg::TXN_W / sira_pkg::MOD_BITS;
    localparam int MCW     = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

    typedef struct packed {
        logic [sira_pkg::ID_W-1:0] start;
        logic [SW-1:0]             ffree;
        logic [MAX_SLICES-1:0]     exh;
        logic [MAX_SLICES-1:0]     touch;
    } t_meta;

    typedef logic [MAX_HISTORY-1:0][HW-1:0] t_row;

    // Configuration registers.
    logic [4:0]  r_sb;
    logic [6:0]  r_nsl;
    logic [4:0]  r_nways;
    logic [3:0]  r_depth;
    logic [63:0] r_chunk;
    logic [63:0] r_first;

    // Controller and datapath.
    sira_pkg::t_state r_state, n_state;
    logic [63:0]                 r_next, n_next;
    logic [sira_pkg::TXN_W-1:0]  r_txn, n_txn;
    logic                        r_given, n_given;
    logic [sira_pkg::SIDX_W-1:0] r_idx, n_idx;
    logic [MCW-1:0]              r_mcnt, n_mcnt;
    logic [WR-1:0]               r_rem, n_rem;
    logic [WW-1:0]               r_way, n_way;
    logic [HW-1:0]               r_slot, n_slot;
    logic [AW-1:0]               r_maddr, n_maddr;
    t_meta                       r_wd, n_wd;
    logic [SW-1:0]               r_sl, n_sl;
    logic                        r_scan, n_scan;
    logic [PW-1:0]               r_pos, n_pos;
    logic [OFW-1:0]              r_off, n_off;
    logic                        r_err, n_err;
    logic                        r_ovalid, n_ovalid;
    logic [63:0]                 r_oid, n_oid;
    logic [3:0]                  r_oway, n_oway;
    logic                        r_ostat, n_ostat;

    t_row                        r_map [MAX_WAYS];
    logic [SLOTS-1:0]            r_valid;

    t_meta                       meta_mem [SLOTS];
    t_meta                       r_mrd;
    logic [sira_pkg::CNT_W-1:0]  cnt_mem [CDEPTH];
    logic [sira_pkg::CNT_W-1:0]  r_crd;

    logic                        meta_re, meta_we, cnt_re, cnt_we;
    t_meta                       meta_wd;
    logic [sira_pkg::CNT_W-1:0]  cnt_wd;
    logic [CAW-1:0]              cnt_addr;
    logic                        valid_set, map_rot, out_load;

    logic [4:0]                  sb_eff;
    logic [NW-1:0]               n_eff;
    logic [WR-1:0]               ways_eff;
    logic [DW-1:0]               depth_eff;
    logic [DW-1:0]               depth_m1;
    logic [16:0]                 max_seq;
    t_row                        row, rot_row;
    logic [WR-1:0]               rem_step;
    logic [WR:0]                 rem_tmp;
    logic [MAX_SLICES-1:0]       exh_sh;
    logic                        scan_hit;
    logic [SW-1:0]               scan_sl;
    logic [AW-1:0]               cur_addr;
    logic [sira_pkg::CNT_W-1:0]  res;
    logic                        cfg_wr;

    // Effective register values after clamping.
    assign sb_eff    = (r_sb > 5'(sira_pkg::SB_MAX)) ? 5'(sira_pkg::SB_MAX) : r_sb;
    assign n_eff     = (r_nsl == 7'd0) ? NW'(1) :
                       ((32'(r_nsl) > MAX_SLICES) ? NW'(MAX_SLICES) : NW'(r_nsl));
    assign ways_eff  = (r_nways == 5'd0) ? WR'(1) :
                       ((32'(r_nways) > MAX_WAYS) ? WR'(MAX_WAYS) : WR'(r_nways));
    assign depth_eff = (r_depth == 4'd0) ? DW'(1) :
                       ((32'(r_depth) > MAX_HISTORY) ? DW'(MAX_HISTORY) : DW'(r_depth));
    assign depth_m1  = depth_eff - DW'(1);
    assign max_seq   = (17'd1 << sb_eff) - 17'd1;

    assign cfg_wr   = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;

    always_comb begin
        case (i_paddr[5:3])
            sira_pkg::REG_SLICE_BITS:  o_prdata = 64'(r_sb);
            sira_pkg::REG_SLICES:      o_prdata = 64'(r_nsl);
            sira_pkg::REG_WAYS:        o_prdata = 64'(r_nways);
            sira_pkg::REG_DEPTH:       o_prdata = 64'(r_depth);
            sira_pkg::REG_CHUNK:       o_prdata = r_chunk;
            sira_pkg::REG_FIRST_START: o_prdata = r_first;
            default:                   o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb    <= sira_pkg::RST_SLICE_BITS;
            r_nsl   <= sira_pkg::RST_SLICES;
            r_nways <= sira_pkg::RST_WAYS;
            r_depth <= sira_pkg::RST_DEPTH;
            r_chunk <= sira_pkg::RST_CHUNK;
            r_first <= sira_pkg::RST_FIRST_START;
        end else if (cfg_wr) begin
            case (i_paddr[5:3])
                sira_pkg::REG_SLICE_BITS:  r_sb    <= i_pwdata[4:0];
                sira_pkg::REG_SLICES:      r_nsl   <= i_pwdata[6:0];
                sira_pkg::REG_WAYS:        r_nways <= i_pwdata[4:0];
                sira_pkg::REG_DEPTH:       r_depth <= i_pwdata[3:0];
                sira_pkg::REG_CHUNK:       r_chunk <= i_pwdata;
                sira_pkg::REG_FIRST_START: r_first <= i_pwdata;
                default: ;
            endcase
        end
    end

    // Remainder of the transaction number, MOD_BITS bits per cycle.
    always_comb begin
        rem_step = r_rem;
        rem_tmp  = '0;
        for (int k = 0; k < sira_pkg::MOD_BITS; k++) begin
            rem_tmp = {rem_step, r_txn[sira_pkg::TXN_W-1-k]};
            if (rem_tmp >= {1'b0, ways_eff}) begin
                rem_tmp = rem_tmp - {1'b0, ways_eff};
            end
            rem_step = rem_tmp[WR-1:0];
        end
    end

    // Free slice search over SCAN_W slices starting at the scan position.
    always_comb begin
        exh_sh   = r_wd.exh >> r_pos;
        scan_hit = 1'b0;
        scan_sl  = '0;
        for (int k = sira_pkg::SCAN_W - 1; k >= 0; k--) begin
            if ((32'(r_pos) + k < 32'(n_eff)) && !exh_sh[k]) begin
                scan_hit = 1'b1;
                scan_sl  = SW'(32'(r_pos) + k);
            end
        end
    end

    // Slot order of the current way, and its shift by one with wrap of the oldest.
    always_comb begin
        row     = r_map[r_way];
        rot_row = row;
        for (int j = 0; j < MAX_HISTORY - 1; j++) begin
            if (32'(j) + 1 < 32'(depth_eff)) begin
                rot_row[j] = row[j + 1];
            end
        end
        rot_row[depth_m1[HW-1:0]] = row[0];
    end

    assign res      = r_wd.touch[r_sl] ? r_crd : '0;
    assign cnt_addr = CAW'(32'(r_maddr) * MAX_SLICES + 32'(r_sl));

    always_comb begin
        n_state   = r_state;
        n_next    = r_next;
        n_txn     = r_txn;
        n_given   = r_given;
        n_idx     = r_idx;
        n_mcnt    = r_mcnt;
        n_rem     = r_rem;
        n_way     = r_way;
        n_slot    = r_slot;
        n_maddr   = r_maddr;
        n_wd      = r_wd;
        n_sl      = r_sl;
        n_scan    = r_scan;
        n_pos     = r_pos;
        n_off     = r_off;
        n_err     = r_err;
        n_oid     = r_oid;
        n_oway    = r_oway;
        n_ostat   = r_ostat;
        meta_re   = 1'b0;
        meta_we   = 1'b0;
        meta_wd   = r_wd;
        cnt_re    = 1'b0;
        cnt_we    = 1'b0;
        cnt_wd    = res + 16'd1;
        valid_set = 1'b0;
        map_rot   = 1'b0;
        out_load  = 1'b0;
        cur_addr  = AW'(32'(r_way) * MAX_HISTORY + 32'(row[r_slot]));

        case (r_state)
            sira_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_txn   = i_req.txn_number;
                    n_given = i_req.slice_named;
                    n_idx   = i_req.slice_index;
                    n_rem   = '0;
                    n_mcnt  = '0;
                    n_state = sira_pkg::ST_MOD;
                end
            end
            sira_pkg::ST_MOD: begin
                n_rem  = rem_step;
                n_txn  = r_txn << sira_pkg::MOD_BITS;
                n_mcnt = r_mcnt + MCW'(1);
                if (32'(r_mcnt) == MOD_CYC - 1) begin
                    n_way   = WW'(rem_step);
                    n_state = sira_pkg::ST_CHK;
                end
            end
            sira_pkg::ST_CHK: begin
                if (r_given && (32'(r_idx) >= 32'(n_eff))) begin
                    n_err   = 1'b1;
                    n_state = sira_pkg::ST_DONE;
                end else begin
                    n_slot  = '0;
                    n_state = sira_pkg::ST_SLOT;
                end
            end
            sira_pkg::ST_SLOT, sira_pkg::ST_NEXT: begin
                if (r_state == sira_pkg::ST_NEXT) begin
                    cur_addr = AW'(32'(r_way) * MAX_HISTORY + 32'(row[0]));
                end
                n_maddr = cur_addr;
                if (r_state == sira_pkg::ST_NEXT &&
                    (32'(r_slot) + 1 < 32'(depth_eff))) begin
                    n_slot  = r_slot + HW'(1);
                    n_state = sira_pkg::ST_SLOT;
                end else if (r_state == sira_pkg::ST_SLOT && r_valid[cur_addr]) begin
                    meta_re = 1'b1;
                    n_state = sira_pkg::ST_META;
                end else begin
                    // Claim a fresh range into this slot.
                    map_rot   = (r_state == sira_pkg::ST_NEXT);
                    valid_set = 1'b1;
                    n_wd      = '0;
                    n_wd.start = r_next;
                    n_next    = r_next + r_chunk;
                    n_sl      = r_given ? SW'(r_idx) : '0;
                    n_scan    = !r_given;
                    n_state   = sira_pkg::ST_CRD;
                end
            end
            sira_pkg::ST_META: begin
                n_wd = r_mrd;
                if (r_given) begin
                    if (r_mrd.exh[SW'(r_idx)]) begin
                        n_state = sira_pkg::ST_NEXT;
                    end else begin
                        n_sl    = SW'(r_idx);
                        n_scan  = 1'b0;
                        n_state = sira_pkg::ST_CRD;
                    end
                end else if (32'(r_mrd.ffree) >= 32'(n_eff)) begin
                    n_state = sira_pkg::ST_NEXT;
                end else begin
                    n_pos   = PW'(r_mrd.ffree);
                    n_state = sira_pkg::ST_SCAN;
                end
            end
            sira_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    n_sl    = scan_sl;
                    n_scan  = 1'b1;
                    n_state = sira_pkg::ST_CRD;
                end else begin
                    n_pos = r_pos + PW'(sira_pkg::SCAN_W);
                    if (32'(r_pos) + sira_pkg::SCAN_W >= 32'(n_eff)) begin
                        n_state = sira_pkg::ST_NEXT;
                    end
                end
            end
            sira_pkg::ST_CRD: begin
                cnt_re  = 1'b1;
                n_state = sira_pkg::ST_UPD;
            end
            sira_pkg::ST_UPD: begin
                cnt_we = 1'b1;
                meta_we = 1'b1;
                meta_wd.touch[r_sl] = 1'b1;
                if ({1'b0, res} == max_seq) begin
                    meta_wd.exh[r_sl] = 1'b1;
                end
                if (r_scan) begin
                    meta_wd.ffree = r_sl;
                end
                n_off   = (OFW'(r_sl) << sb_eff) + OFW'(res);
                n_err   = 1'b0;
                n_state = sira_pkg::ST_DONE;
            end
            sira_pkg::ST_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_oid    = r_err ? '0 : r_wd.start + 64'(r_off);
                    n_oway   = 4'(r_way);
                    n_ostat  = r_err ? sira_pkg::STATUS_BAD_IDX : sira_pkg::STATUS_OK;
                    n_state  = sira_pkg::ST_IDLE;
                end
            end
            default: n_state = sira_pkg::ST_IDLE;
        endcase

        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (o_rsp.ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sira_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_next   <= sira_pkg::RST_FIRST_START;
            r_valid  <= '0;
            for (int w = 0; w < MAX_WAYS; w++) begin
                for (int j = 0; j < MAX_HISTORY; j++) begin
                    r_map[w][j] <= HW'(j);
                end
            end
        end else begin
            r_ovalid <= n_ovalid;
            r_next   <= n_next;
            if (valid_set) begin
                r_valid[n_maddr] <= 1'b1;
            end
            if (map_rot) begin
                r_map[r_way] <= rot_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_txn   <= n_txn;
        r_given <= n_given;
        r_idx   <= n_idx;
        r_mcnt  <= n_mcnt;
        r_rem   <= n_rem;
        r_way   <= n_way;
        r_slot  <= n_slot;
        r_maddr <= n_maddr;
        r_wd    <= n_wd;
        r_sl    <= n_sl;
        r_scan  <= n_scan;
        r_pos   <= n_pos;
        r_off   <= n_off;
        r_err   <= n_err;
        r_oid   <= n_oid;
        r_oway  <= n_oway;
        r_ostat <= n_ostat;
    end

    always_ff @(posedge i_clk) begin
        if (meta_re) begin
            r_mrd <= meta_mem[n_maddr];
        end
        if (meta_we) begin
            meta_mem[r_maddr] <= meta_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_re) begin
            r_crd <= cnt_mem[cnt_addr];
        end
        if (cnt_we) begin
            cnt_mem[cnt_addr] <= cnt_wd;
        end
    end

    assign i_req.ready    = (r_state == sira_pkg::ST_IDLE);
    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.new_id   = r_oid;
    assign o_rsp.way_used = r_oway;
    assign o_rsp.status   = r_ostat;

endmodule

// ===== sim/sliced_id_range_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliced ID range allocator testbench
// Drives ID requests with random gaps and response stalls under several
// register settings. A predictor of the range histories, slice
// counters and the chunk sequence computes the expected ID, way and status
// of each accepted request, and every response transfer is checked in order.
// ----------------------------------------------------------------------------
module sliced_id_range_allocator_test;

    localparam int NW = 16;
    localparam int NH = 8;
    localparam int NS = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [sira_pkg::TXN_W-1:0]  txn;
        logic                        given;
        logic [sira_pkg::SIDX_W-1:0] idx;
    } t_request;

    typedef struct packed {
        logic [sira_pkg::ID_W-1:0]   id;
        logic [sira_pkg::WAYO_W-1:0] way;
        logic                        status;
    } t_grant;

    logic i_clk;
    logic i_rst_n;
    logic i_psel;
    logic i_penable;
    logic i_pwrite;
    logic [sira_pkg::APB_AW-1:0] i_paddr;
    logic [sira_pkg::APB_DW-1:0] i_pwdata;
    logic [sira_pkg::APB_DW-1:0] o_prdata;
    logic o_pready;

    sira_req_if req_if ();
    sira_rsp_if rsp_if ();

    sliced_id_range_allocator u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .o_rsp     (rsp_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // Register copies and allocator state for the predictor.
    logic [4:0]  cfg_slice_bits;
    logic [6:0]  cfg_slices;
    logic [4:0]  cfg_ways;
    logic [3:0]  cfg_depth;
    logic [63:0] cfg_chunk;
    logic [63:0] cfg_first;
    logic [63:0] seq_next;
    bit          slot_live [NW][NH];
    logic [63:0] slot_base [NW][NH];
    int          slot_mark [NW][NH];
    bit          slice_done [NW][NH][NS];
    logic [15:0] slice_cnt [NW][NH][NS];

    t_request pending_reqs[$];
    t_grant   expected_grants[$];
    int  accepted_reqs;
    int  checked_grants;
    int  error_grants;
    int  mismatches;
    int  cycles;
    int  idle_mode;
    bit  req_took;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int slices_now();
        if (cfg_slices == 0) return 1;
        return (cfg_slices > NS) ? NS : int'(cfg_slices);
    endfunction

    task automatic claim_range(input int w, input int s);
        slot_live[w][s] = 1'b1;
        slot_base[w][s] = seq_next;
        slot_mark[w][s] = 0;
        for (int k = 0; k < NS; k++) begin
            slice_done[w][s][k] = 1'b0;
            slice_cnt[w][s][k] = '0;
        end
        seq_next = seq_next + cfg_chunk;
    endtask

    task automatic choose_slice(input int w, input int s, input bit given, input int idx,
                                input int n, output int sl);
        int k;
        if (given) begin
            sl = slice_done[w][s][idx] ? -1 : idx;
            return;
        end
        k = slot_mark[w][s];
        sl = -1;
        while (k < n) begin
            if (!slice_done[w][s][k]) begin
                slot_mark[w][s] = k;
                sl = k;
                return;
            end
            k++;
        end
    endtask

    task automatic draw_id(input int w, input int s, input int sl, input int sb,
                           output logic [63:0] id);
        logic [63:0] top;
        logic [63:0] val;
        top = (64'd1 << sb) - 64'd1;
        val = {48'd0, slice_cnt[w][s][sl]};
        slice_cnt[w][s][sl] = slice_cnt[w][s][sl] + 16'd1;
        if (val == top) slice_done[w][s][sl] = 1'b1;
        id = slot_base[w][s] + (64'(sl) << sb) + val;
    endtask

    task automatic allocate_id(input t_request r, output t_grant g);
        int sb, n, ways, depth, w, sl;
        bit served;
        sb = (cfg_slice_bits > 16) ? 16 : int'(cfg_slice_bits);
        n = slices_now();
        ways = (cfg_ways == 0) ? 1 : ((cfg_ways > NW) ? NW : int'(cfg_ways));
        depth = (cfg_depth == 0) ? 1 : ((cfg_depth > NH) ? NH : int'(cfg_depth));
        w = int'(r.txn % ways);
        served = 1'b0;
        g.way = w[3:0];
        g.id = '0;
        if (r.given && r.idx >= n) begin
            g.status = sira_pkg::STATUS_BAD_IDX;
            return;
        end
        g.status = sira_pkg::STATUS_OK;
        for (int s = 0; s < depth && !served; s++) begin
            if (!slot_live[w][s]) claim_range(w, s);
            choose_slice(w, s, r.given, int'(r.idx), n, sl);
            if (sl >= 0) begin
                draw_id(w, s, sl, sb, g.id);
                served = 1'b1;
            end
        end
        if (!served) begin
            for (int s = 0; s + 1 < depth; s++) begin
                slot_live[w][s] = slot_live[w][s+1];
                slot_base[w][s] = slot_base[w][s+1];
                slot_mark[w][s] = slot_mark[w][s+1];
                for (int k = 0; k < NS; k++) begin
                    slice_done[w][s][k] = slice_done[w][s+1][k];
                    slice_cnt[w][s][k] = slice_cnt[w][s+1][k];
                end
            end
            claim_range(w, depth - 1);
            choose_slice(w, depth - 1, r.given, int'(r.idx), n, sl);
            draw_id(w, depth - 1, sl, sb, g.id);
        end
    endtask

    // Request driver: a request stays valid until its transfer.
    always @(posedge i_clk) begin
        t_grant g;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (i_rst_n && req_if.valid && req_if.ready) begin
            allocate_id(pending_reqs.pop_front(), g);
            expected_grants.push_back(g);
            accepted_reqs <= accepted_reqs + 1;
            req_took = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!(req_if.valid && !req_took)) begin
            req_took = 1'b0;
            if (pending_reqs.size() > 0 &&
                !(idle_mode == 0 && $urandom_range(0, 99) < 6) &&
                !(idle_mode == 1 && $urandom_range(0, 99) < 74)) begin
                req_if.valid <= 1'b1;
                req_if.txn_number <= pending_reqs[0].txn;
                req_if.slice_named <= pending_reqs[0].given;
                req_if.slice_index <= pending_reqs[0].idx;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Response monitor and ready generator.
    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_grants.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("Unexpected response transfer: id=%h way=%0d status=%0d",
                             rsp_if.new_id, rsp_if.way_used, rsp_if.status);
            end else begin
                g = expected_grants.pop_front();
                checked_grants <= checked_grants + 1;
                if (g.status == sira_pkg::STATUS_BAD_IDX) error_grants <= error_grants + 1;
                if (rsp_if.new_id !== g.id || rsp_if.way_used !== g.way ||
                    rsp_if.status !== g.status) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Mismatch: expected id=%h way=%0d status=%0d, got id=%h way=%0d status=%0d",
                                 g.id, g.way, g.status,
                                 rsp_if.new_id, rsp_if.way_used, rsp_if.status);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) rsp_if.ready <= 1'b0;
        else if (idle_mode == 0) rsp_if.ready <= ($urandom_range(0, 99) >= 74);
        else if (idle_mode == 1) rsp_if.ready <= ($urandom_range(0, 99) >= 6);
        else rsp_if.ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        idle_mode <= (accepted_reqs < 450) ? 0 : ((accepted_reqs < 900) ? 1 : 2);
    end

    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        @(negedge i_clk);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {index, 3'b000};
        i_pwdata <= value;
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(negedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        case (index)
            sira_pkg::REG_SLICE_BITS:  cfg_slice_bits = value[4:0];
            sira_pkg::REG_SLICES:      cfg_slices = value[6:0];
            sira_pkg::REG_WAYS:        cfg_ways = value[4:0];
            sira_pkg::REG_DEPTH:       cfg_depth = value[3:0];
            sira_pkg::REG_CHUNK:       cfg_chunk = value;
            sira_pkg::REG_FIRST_START: cfg_first = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_grants.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic queue_req(input logic [31:0] txn, input bit given, input logic [15:0] idx);
        t_request r;
        r.txn = txn;
        r.given = given;
        r.idx = idx;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(input int count);
        logic [31:0] txn;
        logic [15:0] idx;
        for (int i = 0; i < count; i++) begin
            txn = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
            idx = ($urandom_range(0, 99) < 88) ? 16'($urandom_range(0, slices_now() - 1))
                                                : 16'($urandom);
            queue_req(txn, 1'($urandom_range(0, 1)), idx);
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        req_if.valid = 1'b0;
        req_if.txn_number = '0;
        req_if.slice_named = 1'b0;
        req_if.slice_index = '0;
        rsp_if.ready = 1'b0;
        req_took = 1'b0;
        accepted_reqs = 0;
        checked_grants = 0;
        error_grants = 0;
        mismatches = 0;
        cycles = 0;
        idle_mode = 0;
        cfg_slice_bits = sira_pkg::RST_SLICE_BITS;
        cfg_slices = sira_pkg::RST_SLICES;
        cfg_ways = sira_pkg::RST_WAYS;
        cfg_depth = sira_pkg::RST_DEPTH;
        cfg_chunk = sira_pkg::RST_CHUNK;
        cfg_first = sira_pkg::RST_FIRST_START;
        seq_next = sira_pkg::RST_FIRST_START;
        for (int w = 0; w < NW; w++)
            for (int s = 0; s < NH; s++) slot_live[w][s] = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests under the reset settings.
        queue_req(32'd0, 1'b1, 16'd63);
        queue_req(32'hFFFF_FFFF, 1'b1, 16'd64);
        queue_req(32'd1, 1'b1, 16'hFFFF);
        queue_req(32'd5, 1'b0, 16'd0);
        queue_req(32'hFFFF_FFFF, 1'b0, 16'hFFFF);
        queue_req(32'hAAAA_5555, 1'b1, 16'd0);
        queue_req(32'h5555_AAAA, 1'b0, 16'h5555);
        drain();

        // Tiny slices and shallow histories: exhaustion and range drops.
        write_reg(sira_pkg::REG_FIRST_START, 64'hFFFF_FFFF_FFFF_FFF0);
        write_reg(sira_pkg::REG_SLICE_BITS, 64'd1);
        write_reg(sira_pkg::REG_SLICES, 64'd2);
        write_reg(sira_pkg::REG_WAYS, 64'd3);
        write_reg(sira_pkg::REG_DEPTH, 64'd2);
        write_reg(sira_pkg::REG_CHUNK, 64'd5);
        for (int i = 0; i < 4; i++) queue_req(32'd0, 1'b1, 16'd1);
        queue_req(32'd2, 1'b1, 16'd2);
        for (int i = 0; i < 6; i++) queue_req(32'd3, 1'b0, 16'd0);
        queue_random(330);

        write_reg(sira_pkg::REG_SLICE_BITS, 64'd16);
        write_reg(sira_pkg::REG_SLICES, 64'd64);
        write_reg(sira_pkg::REG_WAYS, 64'd16);
        write_reg(sira_pkg::REG_DEPTH, 64'd8);
        write_reg(sira_pkg::REG_CHUNK, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_random(335);

        write_reg(sira_pkg::REG_SLICE_BITS, 64'd2);
        write_reg(sira_pkg::REG_SLICES, 64'd1);
        write_reg(sira_pkg::REG_WAYS, 64'd1);
        write_reg(sira_pkg::REG_DEPTH, 64'd1);
        write_reg(sira_pkg::REG_CHUNK, {$urandom, $urandom});
        queue_random(335);

        write_reg(sira_pkg::REG_SLICE_BITS, 64'd3);
        write_reg(sira_pkg::REG_SLICES, 64'd9);
        write_reg(sira_pkg::REG_WAYS, 64'd7);
        write_reg(sira_pkg::REG_DEPTH, 64'd4);
        write_reg(sira_pkg::REG_CHUNK, 64'd1000);
        queue_random(335);

        $display("Checked %0d responses (%0d out-of-range slice errors) over five settings,",
                 checked_grants, error_grants);
        $display("with sender gaps, receiver stalls and full-rate stretches.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
